>>> rtl/core/depth_keypoint_back_projection_assert.svh
// assertion macros for the depth keypoint back-projection block
`ifndef DEPTH_KEYPOINT_BACK_PROJECTION_ASSERT_SVH
`define DEPTH_KEYPOINT_BACK_PROJECTION_ASSERT_SVH

// same-cycle implication
`define DKBP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DKBP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dkbp_pkg.sv
`timescale 1ns / 1ps

package dkbp_pkg;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 512;

    // field widths
    localparam int COL_FW     = 10;
    localparam int ROW_FW     = 9;
    localparam int DEPTH_W    = 16;
    localparam int KEY_W      = 16;
    localparam int PX_W       = 32;
    localparam int PZ_W       = 17;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 104;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // internal pixel index: a rounded 1/16 position reaches 2048 at most
    localparam int PIX_W = 12;

    // divider: |offset * depth| stays below 2^31, so no saturation is ever needed
    localparam int NUM_W   = 32;
    localparam int MAG_W   = 31;
    localparam int DEN_W   = 16;
    localparam int DIV_LAT = MAG_W + 1;

    localparam logic signed [PZ_W-1:0] Z_NONE = '1;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X     = 3'd0,
        REG_FOCAL_Y     = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_DEPTH_LIMIT = 3'd4,
        REG_COLS_IN_USE = 3'd5,
        REG_ROWS_IN_USE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic               has_depth;
        logic [DEPTH_W-1:0] z;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
    } side_t;

    typedef struct packed {
        logic                   has_depth;
        logic [ROW_FW-1:0]      used_row;
        logic [COL_FW-1:0]      used_col;
        logic signed [PZ_W-1:0] point_z;
        logic signed [PX_W-1:0] point_y;
        logic signed [PX_W-1:0] point_x;
    } result_t;

endpackage

>>> rtl/core/dkbp_frame_mem.sv
`timescale 1ns / 1ps

module dkbp_frame_mem
    import dkbp_pkg::*;
#(
    parameter int ADDR_W = 19
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [DEPTH_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [DEPTH_W-1:0] rd_data
);

    logic [DEPTH_W-1:0] depth_mem [2**ADDR_W];
    logic [DEPTH_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            depth_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= depth_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/dkbp_divider.sv
`timescale 1ns / 1ps

module dkbp_divider
    import dkbp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    adv,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic signed [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [MAG_W+1];
    logic [MAG_W-1:0] acc_reg [MAG_W+1];
    logic             neg_reg [MAG_W+1];

    logic [DEN_W:0]   trial    [MAG_W];
    logic [DEN_W-1:0] rem_next [MAG_W];
    logic [MAG_W-1:0] acc_next [MAG_W];
    logic [NUM_W-1:0] abs_num;
    logic [NUM_W-1:0] qmag;

    assign abs_num = num[NUM_W-1] ? (~num + 1'b1) : num;

    // one quotient bit per stage; acc shifts dividend bits out and quotient bits in
    always_comb begin
        for (int k = 0; k < MAG_W; k++) begin
            trial[k] = {rem_reg[k], acc_reg[k][MAG_W-1]};
            if (trial[k] >= {1'b0, den}) begin
                rem_next[k] = DEN_W'(trial[k] - {1'b0, den});
                acc_next[k] = {acc_reg[k][MAG_W-2:0], 1'b1};
            end else begin
                rem_next[k] = trial[k][DEN_W-1:0];
                acc_next[k] = {acc_reg[k][MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg_reg[0] <= num[NUM_W-1];
            acc_reg[0] <= abs_num[MAG_W-1:0];
            rem_reg[0] <= '0;
            for (int k = 0; k < MAG_W; k++) begin
                neg_reg[k+1] <= neg_reg[k];
                acc_reg[k+1] <= acc_next[k];
                rem_reg[k+1] <= rem_next[k];
            end
        end
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign qmag = {1'b0, acc_reg[MAG_W]};
    assign quo  = $signed(neg_reg[MAG_W] ? (~qmag + 1'b1) : qmag);

endmodule

>>> rtl/core/dkbp_out_buf.sv
`timescale 1ns / 1ps

module dkbp_out_buf
    import dkbp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    head_reg;
    result_t    spare_reg;
    logic       take;

    assign out_valid = (count_reg != CNT_EMPTY);
    assign room      = (count_reg != CNT_FULL);
    assign take      = out_valid && out_ready;
    assign out_data  = head_reg;

    assign count_next = count_reg + 2'(in_valid) - 2'(take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_EMPTY;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if ((count_reg == CNT_EMPTY) || ((count_reg == CNT_ONE) && take)) begin
            head_reg <= in_data;
        end else if ((count_reg == CNT_FULL) && take) begin
            head_reg <= spare_reg;
        end
        if ((count_reg == CNT_ONE) && in_valid && !take) begin
            spare_reg <= in_data;
        end
    end

endmodule

>>> rtl/core/depth_keypoint_back_projection.sv
// query path: a request passes the frame read, the product register, the divider stages and
//   the output buffer before m_tvalid; loads give no result and land in the frame at accept
// throughput: one request per cycle, loads and queries mixed; the 32-stage divider and
//   the registered frame memory read port set the pipeline, stalling only when both output slots hold
// reset: config registers return to defaults and the pipeline empties; the frame memory
//   is not cleared, so pixels read as undefined until written
`timescale 1ns / 1ps

module depth_keypoint_back_projection
    import dkbp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // pixel_col[9:0], pixel_row[18:10], pixel_depth[34:19], key_u[50:35], key_v[66:51]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_x[31:0], point_y[63:32], point_z[80:64], used_col[90:81], used_row[99:91]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // has_depth[0]
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;

    // configuration
    logic [15:0] focal_x_reg;
    logic [15:0] focal_y_reg;
    logic [13:0] center_x_reg;
    logic [12:0] center_y_reg;
    logic [15:0] depth_limit_reg;
    logic [10:0] cols_in_use_reg;
    logic [9:0]  rows_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg     <= 16'd8400;
            focal_y_reg     <= 16'd8400;
            center_x_reg    <= 14'd5120;
            center_y_reg    <= 13'd3840;
            depth_limit_reg <= 16'd0;
            cols_in_use_reg <= 11'd640;
            rows_in_use_reg <= 10'd480;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_FOCAL_X:     focal_x_reg     <= cfg_wdata;
                REG_FOCAL_Y:     focal_y_reg     <= cfg_wdata;
                REG_CENTER_X:    center_x_reg    <= cfg_wdata[13:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_wdata[12:0];
                REG_DEPTH_LIMIT: depth_limit_reg <= cfg_wdata;
                REG_COLS_IN_USE: cols_in_use_reg <= cfg_wdata[10:0];
                REG_ROWS_IN_USE: rows_in_use_reg <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // request fields
    logic [COL_FW-1:0]  in_col;
    logic [ROW_FW-1:0]  in_row;
    logic [DEPTH_W-1:0] in_depth;
    logic [KEY_W-1:0]   in_key_u;
    logic [KEY_W-1:0]   in_key_v;
    logic               in_accept;
    logic               adv;

    assign in_col   = s_tdata[9:0];
    assign in_row   = s_tdata[18:10];
    assign in_depth = s_tdata[34:19];
    assign in_key_u = s_tdata[50:35];
    assign in_key_v = s_tdata[66:51];

    assign s_tready  = adv;
    assign in_accept = s_tvalid && s_tready;

    // round half up, negative clamps to 0, then clamp to the last usable index
    function automatic logic [PIX_W-1:0] to_pixel(input logic [KEY_W-1:0] pos,
                                                  input logic [PIX_W-1:0] pmax);
        logic [KEY_W:0]   t;
        logic [PIX_W-1:0] p;
        t = {pos[KEY_W-1], pos} + 17'd8;
        p = t[15:4];
        if (t[KEY_W]) begin
            p = '0;
        end else if (p > pmax) begin
            p = pmax;
        end
        return p;
    endfunction

    logic [PIX_W-1:0] col_max;
    logic [PIX_W-1:0] row_max;
    logic [PIX_W-1:0] q_col;
    logic [PIX_W-1:0] q_row;

    always_comb begin
        if (cols_in_use_reg == '0) begin
            col_max = '0;
        end else if ({2'b0, cols_in_use_reg} > 13'(MAX_COLS)) begin
            col_max = PIX_W'(MAX_COLS - 1);
        end else begin
            col_max = {1'b0, cols_in_use_reg} - 12'd1;
        end
        if (rows_in_use_reg == '0) begin
            row_max = '0;
        end else if ({3'b0, rows_in_use_reg} > 13'(MAX_ROWS)) begin
            row_max = PIX_W'(MAX_ROWS - 1);
        end else begin
            row_max = {2'b0, rows_in_use_reg} - 12'd1;
        end
    end

    assign q_col = to_pixel(in_key_u, col_max);
    assign q_row = to_pixel(in_key_v, row_max);

    // frame memory access
    logic [PIX_W-1:0]   ld_col;
    logic [PIX_W-1:0]   ld_row;
    logic               ld_in_frame;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [DEPTH_W-1:0] mem_rd_data;

    assign ld_col      = PIX_W'(in_col);
    assign ld_row      = PIX_W'(in_row);
    assign ld_in_frame = ({3'b0, in_col} < 13'(MAX_COLS)) && ({4'b0, in_row} < 13'(MAX_ROWS));
    assign mem_wr_en   = in_accept && (cmd_t'(s_tuser) == CMD_LOAD) && ld_in_frame;
    assign mem_wr_addr = {ld_row[ROW_W-1:0], ld_col[COL_W-1:0]};
    assign mem_rd_addr = {q_row[ROW_W-1:0], q_col[COL_W-1:0]};

    dkbp_frame_mem #(
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (in_depth),
        .rd_en   (adv),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // stage 1: depth arrives from memory
    logic             p1_valid_reg;
    logic [PIX_W-1:0] p1_col_reg;
    logic [PIX_W-1:0] p1_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= in_accept && (cmd_t'(s_tuser) == CMD_QUERY);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_col_reg <= q_col;
            p1_row_reg <= q_row;
        end
    end

    logic               p1_has;
    logic signed [16:0] off_x;
    logic signed [16:0] off_y;
    logic signed [16:0] z_s;
    logic signed [33:0] prod_x_full;
    logic signed [33:0] prod_y_full;

    assign p1_has = (mem_rd_data != '0)
                 && ((depth_limit_reg == '0) || (mem_rd_data <= depth_limit_reg));
    assign off_x = $signed({1'b0, p1_col_reg, 4'b0}) - $signed({3'b0, center_x_reg});
    assign off_y = $signed({1'b0, p1_row_reg, 4'b0}) - $signed({4'b0, center_y_reg});
    assign z_s   = $signed({1'b0, mem_rd_data});
    assign prod_x_full = off_x * z_s;
    assign prod_y_full = off_y * z_s;

    // stage 2: products registered ahead of the dividers
    logic                    s2_valid_reg;
    side_t                   s2_side_reg;
    logic signed [NUM_W-1:0] prod_x_reg;
    logic signed [NUM_W-1:0] prod_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_side_reg.has_depth <= p1_has;
            s2_side_reg.z         <= mem_rd_data;
            s2_side_reg.col       <= p1_col_reg;
            s2_side_reg.row       <= p1_row_reg;
            prod_x_reg            <= prod_x_full[NUM_W-1:0];
            prod_y_reg            <= prod_y_full[NUM_W-1:0];
        end
    end

    // dividers, zero focal acts as one
    logic [DEN_W-1:0]        div_x;
    logic [DEN_W-1:0]        div_y;
    logic signed [NUM_W-1:0] quo_x;
    logic signed [NUM_W-1:0] quo_y;

    assign div_x = (focal_x_reg == '0) ? 16'd1 : focal_x_reg;
    assign div_y = (focal_y_reg == '0) ? 16'd1 : focal_y_reg;

    dkbp_divider u_div_x (
        .aclk (aclk),
        .adv  (adv),
        .num  (prod_x_reg),
        .den  (div_x),
        .quo  (quo_x)
    );

    dkbp_divider u_div_y (
        .aclk (aclk),
        .adv  (adv),
        .num  (prod_y_reg),
        .den  (div_y),
        .quo  (quo_y)
    );

    // sideband delay line matched to the divider latency
    logic  dl_valid_reg [DIV_LAT];
    side_t dl_side_reg  [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                dl_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            dl_valid_reg[0] <= s2_valid_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                dl_valid_reg[k] <= dl_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl_side_reg[0] <= s2_side_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                dl_side_reg[k] <= dl_side_reg[k-1];
            end
        end
    end

    // result assembly
    side_t   last_side;
    result_t res;
    result_t out_res;
    logic    res_valid;

    assign last_side = dl_side_reg[DIV_LAT-1];
    assign res_valid = dl_valid_reg[DIV_LAT-1] && adv;

    always_comb begin
        res.has_depth = last_side.has_depth;
        res.used_row  = last_side.row[ROW_FW-1:0];
        res.used_col  = last_side.col[COL_FW-1:0];
        if (last_side.has_depth) begin
            res.point_x = quo_x;
            res.point_y = quo_y;
            res.point_z = $signed({1'b0, last_side.z});
        end else begin
            res.point_x = '0;
            res.point_y = '0;
            res.point_z = Z_NONE;
        end
    end

    dkbp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .room      (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {4'b0, out_res.used_row, out_res.used_col, out_res.point_z,
                      out_res.point_y, out_res.point_x};
    assign m_tuser = out_res.has_depth;

    `include "depth_keypoint_back_projection_assert.svh"

    `DKBP_ASSERT_NXT(a_load_no_result, aclk, aresetn, in_accept && (cmd_t'(s_tuser) == CMD_LOAD), !p1_valid_reg, "load request entered the result pipeline")
    `DKBP_ASSERT_NXT(a_query_enters, aclk, aresetn, in_accept && (cmd_t'(s_tuser) == CMD_QUERY), p1_valid_reg, "query request lost at pipeline entry")
    `DKBP_ASSERT_IMP(a_depth_positive, aclk, aresetn, m_tvalid && out_res.has_depth, out_res.point_z > 0, "valid point without positive depth")
    `DKBP_ASSERT_IMP(a_stall_needs_output, aclk, aresetn, !s_tready, m_tvalid, "input stalled while output buffer empty")

endmodule
